// ----- hw/rtl/timestamp_ordered_event_queue_macros.svh -----
// assertion macros used by the checker file toeq_checker.sv
`ifndef TIMESTAMP_ORDERED_EVENT_QUEUE_MACROS_SVH
`define TIMESTAMP_ORDERED_EVENT_QUEUE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TOEQ_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("toeq assertion failed");

// next-cycle implication, disabled while in reset
`define TOEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("toeq assertion failed");

`endif

// ----- hw/rtl/toeq_pkg.sv -----
`default_nettype none

package toeq_pkg;

  localparam int unsigned QueueDepthDefault = 64;
  localparam int unsigned TimeWidthDefault  = 64;
  localparam int unsigned DataWidthDefault  = 32;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_POP    = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic shift_in;
    logic shift_out;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/toeq_cell.sv -----
`default_nettype none

module toeq_cell #(
  parameter int unsigned TIME_WIDTH = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire toeq_pkg::cell_ctrl_t  ctrl_i,
  input  wire logic [TIME_WIDTH-1:0] new_time_i,
  input  wire logic [DATA_WIDTH-1:0] new_data_i,
  input  wire logic                  valid_i,
  input  wire logic                  prev_le_i,
  input  wire logic [TIME_WIDTH-1:0] left_time_i,
  input  wire logic [DATA_WIDTH-1:0] left_data_i,
  input  wire logic [TIME_WIDTH-1:0] right_time_i,
  input  wire logic [DATA_WIDTH-1:0] right_data_i,
  output logic                       le_o,
  output logic [TIME_WIDTH-1:0]      time_o,
  output logic [DATA_WIDTH-1:0]      data_o
);
  import toeq_pkg::*;

  logic [TIME_WIDTH-1:0] time_q, time_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;

  // held entry stays ahead of the new one, ties included
  assign le_o = valid_i && (time_q <= new_time_i);

  always_comb begin
    time_d = time_q;
    data_d = data_q;
    priority if (ctrl_i.shift_in && !le_o) begin
      if (prev_le_i) begin
        time_d = new_time_i;
        data_d = new_data_i;
      end else begin
        time_d = left_time_i;
        data_d = left_data_i;
      end
    end else if (ctrl_i.shift_out) begin
      time_d = right_time_i;
      data_d = right_data_i;
    end else begin
      time_d = time_q;
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
    data_q <= data_d;
  end

  assign time_o = time_q;
  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- hw/rtl/timestamp_ordered_event_queue.sv -----
// timestamp ordered event queue
// input channel: in_valid_i/in_ready_o with mode_i, event_time_i, event_data_i.
//   mode insert adds an event behind every held event of equal or smaller time,
//   mode pop removes the event with the smallest time.
// output channel: out_valid_o/out_ready_i, one result per input transfer:
//   status_o (ok, full, empty), popped_time_o/popped_data_o (zero unless a
//   successful pop) and occupancy_o, the count after the operation.
// result: registered, and shows in the cycle after the input transfer.
// throughput: one item per cycle unless the output stalls; every cell of the sorted
//   chain compares its key with the broadcast key and moves in the same cycle.
// reset: the queue is empty and no result is pending; no clearing pass.
// stall: while a result waits and out_ready_i is low, in_ready_o is low and the
//   result holds; with out_ready_i high a new item is taken in the same cycle.
`default_nettype none

module timestamp_ordered_event_queue #(
  parameter int unsigned QUEUE_DEPTH = toeq_pkg::QueueDepthDefault,
  parameter int unsigned TIME_WIDTH  = toeq_pkg::TimeWidthDefault,
  parameter int unsigned DATA_WIDTH  = toeq_pkg::DataWidthDefault,
  localparam int unsigned CntW       = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  mode_i,
  input  wire logic [TIME_WIDTH-1:0] event_time_i,
  input  wire logic [DATA_WIDTH-1:0] event_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [1:0]                 status_o,
  output logic [TIME_WIDTH-1:0]      popped_time_o,
  output logic [DATA_WIDTH-1:0]      popped_data_o,
  output logic [CntW-1:0]            occupancy_o
);
  import toeq_pkg::*;

  logic [CntW-1:0]       count_q, count_d;
  logic                  accept, full, empty;
  cell_ctrl_t            ctrl;
  logic [QUEUE_DEPTH-1:0] cell_le;
  logic [TIME_WIDTH-1:0] cell_time [QUEUE_DEPTH];
  logic [DATA_WIDTH-1:0] cell_data [QUEUE_DEPTH];

  logic                  out_valid_q;
  status_e               status_q, status_d;
  logic [TIME_WIDTH-1:0] ptime_q, ptime_d;
  logic [DATA_WIDTH-1:0] pdata_q, pdata_d;
  logic [CntW-1:0]       occ_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(QUEUE_DEPTH));
  assign empty      = (count_q == '0);

  assign ctrl.shift_in  = accept && (mode_i == MODE_INSERT) && !full;
  assign ctrl.shift_out = accept && (mode_i == MODE_POP) && !empty;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                  prev_le;
    logic [TIME_WIDTH-1:0] left_time, right_time;
    logic [DATA_WIDTH-1:0] left_data, right_data;

    if (i == 0) begin : g_head
      assign prev_le   = 1'b1;
      assign left_time = event_time_i;
      assign left_data = event_data_i;
    end else begin : g_body
      assign prev_le   = cell_le[i-1];
      assign left_time = cell_time[i-1];
      assign left_data = cell_data[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_time = cell_time[i];
      assign right_data = cell_data[i];
    end else begin : g_mid
      assign right_time = cell_time[i+1];
      assign right_data = cell_data[i+1];
    end

    toeq_cell #(
      .TIME_WIDTH(TIME_WIDTH),
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .new_time_i  (event_time_i),
      .new_data_i  (event_data_i),
      .valid_i     (count_q > CntW'(i)),
      .prev_le_i   (prev_le),
      .left_time_i (left_time),
      .left_data_i (left_data),
      .right_time_i(right_time),
      .right_data_i(right_data),
      .le_o        (cell_le[i]),
      .time_o      (cell_time[i]),
      .data_o      (cell_data[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    ptime_d  = '0;
    pdata_d  = '0;
    if (ctrl.shift_in) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.shift_out) begin
      count_d = count_q - CntW'(1);
      ptime_d = cell_time[0];
      pdata_d = cell_data[0];
    end
    if (mode_i == MODE_INSERT && full) begin
      status_d = ST_FULL;
    end else if (mode_i == MODE_POP && empty) begin
      status_d = ST_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      ptime_q  <= ptime_d;
      pdata_q  <= pdata_d;
      occ_q    <= count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign popped_time_o = ptime_q;
  assign popped_data_o = pdata_q;
  assign occupancy_o   = occ_q;

endmodule

`default_nettype wire

// ----- hw/rtl/toeq_checker.sv -----
`default_nettype none

`include "timestamp_ordered_event_queue_macros.svh"

module toeq_checker #(
  parameter int unsigned QUEUE_DEPTH = toeq_pkg::QueueDepthDefault,
  parameter int unsigned TIME_WIDTH  = toeq_pkg::TimeWidthDefault,
  parameter int unsigned DATA_WIDTH  = toeq_pkg::DataWidthDefault,
  localparam int unsigned CntW       = $clog2(QUEUE_DEPTH + 1)
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire logic [1:0]            status_o,
  input wire logic [TIME_WIDTH-1:0] popped_time_o,
  input wire logic [DATA_WIDTH-1:0] popped_data_o,
  input wire logic [CntW-1:0]       occupancy_o
);
  import toeq_pkg::*;

  logic in_xfer, out_full, out_empty, empty_clean, out_stall;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_full    = out_valid_o && (status_o == ST_FULL);
  assign out_empty   = out_valid_o && (status_o == ST_EMPTY);
  assign empty_clean = (occupancy_o == '0) && (popped_time_o == '0) && (popped_data_o == '0);
  assign out_stall   = out_valid_o && !out_ready_i && !in_xfer;

  `TOEQ_ASSERT(a_full_occ, clk_i, rst_ni, out_full, occupancy_o == CntW'(QUEUE_DEPTH))
  `TOEQ_ASSERT(a_empty_zero, clk_i, rst_ni, out_empty, empty_clean)
  `TOEQ_ASSERT(a_occ_bound, clk_i, rst_ni, out_valid_o, occupancy_o <= CntW'(QUEUE_DEPTH))
  `TOEQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable({status_o, occupancy_o, popped_time_o, popped_data_o}))

endmodule

bind timestamp_ordered_event_queue toeq_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH),
  .TIME_WIDTH (TIME_WIDTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_toeq_checker (.*);

`default_nettype wire
